@@ hw/rtl/ewa_pkg.sv @@
// ----------------------------------------------------------------------------
// ewa_pkg
// Shared opcodes, widths and the pipeline word record of the 256-bit word alu.
// ----------------------------------------------------------------------------
package ewa_pkg;

   localparam int WORD_W    = 256;
   localparam int LIMB_W    = 64;
   localparam int DIV_STEPS = 256;
   localparam int DIG_W     = 32;
   localparam int MUL_ROWS  = WORD_W / DIG_W;
   localparam int MUL_LAT   = MUL_ROWS + 1;

   localparam logic [7:0] OP_ADD    = 8'h01;
   localparam logic [7:0] OP_MUL    = 8'h02;
   localparam logic [7:0] OP_SUB    = 8'h03;
   localparam logic [7:0] OP_DIV    = 8'h04;
   localparam logic [7:0] OP_MOD    = 8'h06;
   localparam logic [7:0] OP_LT     = 8'h10;
   localparam logic [7:0] OP_GT     = 8'h11;
   localparam logic [7:0] OP_SLT    = 8'h12;
   localparam logic [7:0] OP_SGT    = 8'h13;
   localparam logic [7:0] OP_EQ     = 8'h14;
   localparam logic [7:0] OP_ZTEST  = 8'h15;
   localparam logic [7:0] OP_AND    = 8'h16;
   localparam logic [7:0] OP_OR     = 8'h17;
   localparam logic [7:0] OP_XOR    = 8'h18;
   localparam logic [7:0] OP_NOT    = 8'h19;
   localparam logic [7:0] OP_SHL    = 8'h1B;
   localparam logic [7:0] OP_SHR    = 8'h1C;

   localparam logic [7:0] TWIN_LO   = 8'hC1;
   localparam logic [7:0] TWIN_HI   = 8'hDC;
   localparam logic [7:0] TWIN_BASE = 8'hC0;

   typedef enum logic [1:0] {
      K_ALU,
      K_MUL,
      K_DIV,
      K_MOD
   } kind_type;

   typedef struct packed {
      logic               v;
      kind_type           kind;
      logic               narrow;
      logic               inv;
      logic               dz;
      logic [WORD_W-1:0]  rem;
      logic [WORD_W-1:0]  qd;
      logic [WORD_W-1:0]  dvs;
      logic [WORD_W-1:0]  res;
   } rec_type;

endpackage

@@ hw/rtl/evm_word_alu.sv @@
// ----------------------------------------------------------------------------
// evm_word_alu
// 256-bit stack machine arithmetic and logic unit with 64-bit twin opcodes.
// ----------------------------------------------------------------------------
// Takes one word every cycle while the skid register is empty and returns
// the results in order. The pipeline follows the divider: 256 restoring
// steps, one quotient bit per pipeline stage, after one decode stage and
// before one output register. All opcodes travel through the same pipeline,
// so results leave in the order the words came in. A skid register behind
// the output lets the pipeline keep taking words while one result waits;
// the pipeline stalls only when both are full.
module evm_word_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_type,
   input  logic [63:0] req_top_limb0,
   input  logic [63:0] req_top_limb1,
   input  logic [63:0] req_top_limb2,
   input  logic [63:0] req_top_limb3,
   input  logic [63:0] req_next_limb0,
   input  logic [63:0] req_next_limb1,
   input  logic [63:0] req_next_limb2,
   input  logic [63:0] req_next_limb3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_res_limb0,
   output logic [63:0] rsp_res_limb1,
   output logic [63:0] rsp_res_limb2,
   output logic [63:0] rsp_res_limb3,
   output logic        rsp_invalid_op
);
   import ewa_pkg::*;

   rec_type             chain [DIV_STEPS+1];
   rec_type             merged;
   logic [WORD_W-1:0]   mul_res;
   logic                en;
   logic [WORD_W-1:0]   fin_res;
   logic                fin_v, fin_inv;
   logic [WORD_W-1:0]   rsp_res_ff, skid_res_ff;
   logic                rsp_inv_ff, skid_inv_ff;
   logic                rsp_v_ff, skid_v_ff;
   logic                out_free;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   ewa_front u_front (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .valid  (req_valid),
      .op     (req_type),
      .top_w  ({req_top_limb3, req_top_limb2, req_top_limb1, req_top_limb0}),
      .next_w ({req_next_limb3, req_next_limb2, req_next_limb1, req_next_limb0}),
      .rec    (chain[0])
   );

   ewa_mul u_mul (
      .clock (clock),
      .en    (en),
      .a     (chain[0].qd),
      .b     (chain[0].dvs),
      .prod  (mul_res)
   );

   always_comb begin
      merged = chain[MUL_LAT];
      if (chain[MUL_LAT].kind == K_MUL) merged.res = mul_res;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      if (k == MUL_LAT) begin : g_merge
         ewa_div_step u_step (
            .clock (clock),
            .reset (reset),
            .en    (en),
            .prev  (merged),
            .rec   (chain[k+1])
         );
      end else begin : g_plain
         ewa_div_step u_step (
            .clock (clock),
            .reset (reset),
            .en    (en),
            .prev  (chain[k]),
            .rec   (chain[k+1])
         );
      end
   end

   // result select, divide by zero and 64-bit masking
   always_comb begin
      case (chain[DIV_STEPS].kind)
         K_DIV:   fin_res = chain[DIV_STEPS].dz ? '0 : chain[DIV_STEPS].qd;
         K_MOD:   fin_res = chain[DIV_STEPS].dz ? '0 : chain[DIV_STEPS].rem;
         default: fin_res = chain[DIV_STEPS].res;
      endcase
      if (chain[DIV_STEPS].narrow) fin_res[WORD_W-1:LIMB_W] = '0;
      fin_v   = chain[DIV_STEPS].v;
      fin_inv = chain[DIV_STEPS].inv;
   end

   assign out_free = !rsp_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (en && fin_v) begin
         if (out_free) begin
            rsp_v_ff   <= 1'b1;
            rsp_res_ff <= fin_res;
            rsp_inv_ff <= fin_inv;
         end else begin
            skid_v_ff   <= 1'b1;
            skid_res_ff <= fin_res;
            skid_inv_ff <= fin_inv;
         end
      end else if (rsp_v_ff && rsp_ready) begin
         if (skid_v_ff) begin
            rsp_res_ff <= skid_res_ff;
            rsp_inv_ff <= skid_inv_ff;
            skid_v_ff  <= 1'b0;
         end else begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_v_ff;
   assign rsp_res_limb0  = rsp_res_ff[0*LIMB_W +: LIMB_W];
   assign rsp_res_limb1  = rsp_res_ff[1*LIMB_W +: LIMB_W];
   assign rsp_res_limb2  = rsp_res_ff[2*LIMB_W +: LIMB_W];
   assign rsp_res_limb3  = rsp_res_ff[3*LIMB_W +: LIMB_W];
   assign rsp_invalid_op = rsp_inv_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_v_ff)
      else $error("skid word held without an output word");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(rsp_v_ff && !rsp_ready))
      else $error("skid filled while output was free");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_inv_ff) |-> (rsp_res_ff == '0))
      else $error("invalid opcode with non-zero result");

endmodule

@@ hw/rtl/ewa_front.sv @@
// ----------------------------------------------------------------------------
// ewa_front
// Opcode decode, operand widening and the combinational add, subtract, logic,
// compare and shift operations; registers the first pipeline word record.
// ----------------------------------------------------------------------------
module ewa_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    valid,
   input  logic [7:0]              op,
   input  logic [ewa_pkg::WORD_W-1:0] top_w,
   input  logic [ewa_pkg::WORD_W-1:0] next_w,
   output ewa_pkg::rec_type        rec
);
   import ewa_pkg::*;

   rec_type             rec_ff, rec_in;
   logic                narrow;
   logic [7:0]          base;
   logic [WORD_W-1:0]   t, n, sgn;
   logic                big;

   function automatic logic slt_fn(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                   input logic nw, input logic [WORD_W-1:0] s);
      logic r;
      if (nw) r = (a ^ s) < (b ^ s);
      else if (a[WORD_W-1] != b[WORD_W-1]) r = a[WORD_W-1];
      else r = a < b;
      return r;
   endfunction

   always_comb begin
      narrow = (op >= TWIN_LO) && (op <= TWIN_HI);
      base   = narrow ? (op - TWIN_BASE) : op;
      t      = narrow ? {{(WORD_W-LIMB_W){1'b0}}, top_w[LIMB_W-1:0]} : top_w;
      n      = narrow ? {{(WORD_W-LIMB_W){1'b0}}, next_w[LIMB_W-1:0]} : next_w;
      sgn    = {{(WORD_W-LIMB_W){1'b0}}, 1'b1, {(LIMB_W-1){1'b0}}};
      big    = |t[WORD_W-1:8];

      rec_in        = '0;
      rec_in.v      = valid;
      rec_in.narrow = narrow;
      rec_in.qd     = t;
      rec_in.dvs    = n;
      rec_in.dz     = (n == '0);
      rec_in.kind   = K_ALU;
      unique case (base)
         OP_ADD:    rec_in.res = t + n;
         OP_MUL:    rec_in.kind = K_MUL;
         OP_SUB:    rec_in.res = t - n;
         OP_DIV:    rec_in.kind = K_DIV;
         OP_MOD:    rec_in.kind = K_MOD;
         OP_LT:     rec_in.res = {{(WORD_W-1){1'b0}}, t < n};
         OP_GT:     rec_in.res = {{(WORD_W-1){1'b0}}, n < t};
         OP_SLT:    rec_in.res = {{(WORD_W-1){1'b0}}, slt_fn(t, n, narrow, sgn)};
         OP_SGT:    rec_in.res = {{(WORD_W-1){1'b0}}, slt_fn(n, t, narrow, sgn)};
         OP_EQ:     rec_in.res = {{(WORD_W-1){1'b0}}, t == n};
         OP_ZTEST:  rec_in.res = {{(WORD_W-1){1'b0}}, t == '0};
         OP_AND:    rec_in.res = t & n;
         OP_OR:     rec_in.res = t | n;
         OP_XOR:    rec_in.res = t ^ n;
         OP_NOT:    rec_in.res = ~t;
         OP_SHL:    rec_in.res = big ? '0 : (n << t[7:0]);
         OP_SHR:    rec_in.res = big ? '0 : (n >> t[7:0]);
         default:   rec_in.inv = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.v <= 1'b0;
      end else if (en) begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;

endmodule

@@ hw/rtl/ewa_mul.sv @@
// ----------------------------------------------------------------------------
// ewa_mul
// Pipelined 256 x 256 multiplier, low half: 32-bit digit products in the
// first stage, then one row of partial products accumulated per stage.
// ----------------------------------------------------------------------------
module ewa_mul (
   input  logic                       clock,
   input  logic                       en,
   input  logic [ewa_pkg::WORD_W-1:0] a,
   input  logic [ewa_pkg::WORD_W-1:0] b,
   output logic [ewa_pkg::WORD_W-1:0] prod
);
   import ewa_pkg::*;

   logic [2*DIG_W-1:0] prod_ff [MUL_ROWS][MUL_ROWS][MUL_ROWS];
   logic [WORD_W-1:0]  acc_ff  [MUL_ROWS];
   logic [WORD_W-1:0]  row_in  [MUL_ROWS];

   // the even digit products of a row do not overlap one another, nor do the odd ones
   function automatic logic [WORD_W-1:0] row_fn(input logic [2*DIG_W-1:0] pr [MUL_ROWS],
                                                input int i);
      logic [WORD_W-1:0] ev, od, tmp;
      ev = '0;
      od = '0;
      for (int j = 0; j < MUL_ROWS; j++) begin
         if (i + j < MUL_ROWS) begin
            tmp = {{(WORD_W-2*DIG_W){1'b0}}, pr[j]} << (DIG_W * (i + j));
            if (j % 2 == 0) ev = ev | tmp;
            else od = od | tmp;
         end
      end
      return ev + od;
   endfunction

   always_comb begin
      for (int s = 0; s < MUL_ROWS; s++) begin
         row_in[s] = row_fn(prod_ff[s][s], s);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < MUL_ROWS; i++) begin
            for (int j = 0; j < MUL_ROWS; j++) begin
               if (i + j < MUL_ROWS)
                  prod_ff[0][i][j] <= a[DIG_W*i +: DIG_W] * b[DIG_W*j +: DIG_W];
               else
                  prod_ff[0][i][j] <= '0;
            end
         end
         for (int s = 1; s < MUL_ROWS; s++) begin
            prod_ff[s] <= prod_ff[s-1];
         end
         acc_ff[0] <= row_in[0];
         for (int s = 1; s < MUL_ROWS; s++) begin
            acc_ff[s] <= acc_ff[s-1] + row_in[s];
         end
      end
   end

   assign prod = acc_ff[MUL_ROWS-1];

endmodule

@@ hw/rtl/ewa_div_step.sv @@
// ----------------------------------------------------------------------------
// ewa_div_step
// One restoring division step: shifts one dividend bit into the remainder,
// subtracts the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module ewa_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  ewa_pkg::rec_type prev,
   output ewa_pkg::rec_type rec
);
   import ewa_pkg::*;

   rec_type             rec_ff, rec_in;
   logic [WORD_W:0]     part;
   logic [WORD_W+1:0]   diff;
   logic                fits;

   always_comb begin
      part   = {prev.rem, prev.qd[WORD_W-1]};
      diff   = {1'b0, part} - {2'b00, prev.dvs};
      fits   = !diff[WORD_W+1];
      rec_in = prev;
      rec_in.rem = fits ? diff[WORD_W-1:0] : part[WORD_W-1:0];
      rec_in.qd  = {prev.qd[WORD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.v <= 1'b0;
      end else if (en) begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;

endmodule
